// File: rtl/core/utf8_cjk_char_count_check_defines.svh
// assertion helpers shared by the rtl
`ifndef UTF8_CJK_CHAR_COUNT_CHECK_DEFINES_SVH
`define UTF8_CJK_CHAR_COUNT_CHECK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ucc_pkg.sv
package ucc_pkg;

  localparam int CHAR_W = 16;
  localparam int LIMIT_W = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_ALNUM = 2'd1,
    MODE_DIGIT = 2'd2,
    MODE_TRUNC = 2'd3
  } mode_t;

  typedef enum logic {
    REG_MODE  = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  localparam logic [7:0] CH_0 = 8'd48;
  localparam logic [7:0] CH_9 = 8'd57;
  localparam logic [7:0] CH_UA = 8'd65;
  localparam logic [7:0] CH_UZ = 8'd90;
  localparam logic [7:0] CH_LA = 8'd97;
  localparam logic [7:0] CH_LZ = 8'd122;
  localparam logic [23:0] CJK_LO = 24'hE4B880;
  localparam logic [23:0] CJK_HI = 24'hE9BEB5;

  // one item's worth of output work
  typedef struct packed {
    logic [2:0][7:0]   bytes;
    logic [1:0]        nkeep;
    logic              summ;
    logic [CHAR_W-1:0] cnt;
    logic              fail;
  } rec_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  function automatic logic is_cjk(input logic [7:0] c0, input logic [7:0] c1,
                                  input logic [7:0] c2);
    logic [23:0] v;
    v = {c0, c1, c2};
    is_cjk = (c1[7:6] == 2'b10) && (c2[7:6] == 2'b10) && (v >= CJK_LO) && (v <= CJK_HI);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

endpackage

// File: rtl/core/utf8_cjk_char_count_check.sv
// channel  | dir | handshake          | payload
// in_      | in  | in_tvalid/tready   | tdata[7:0] data_byte, tlast end_of_string
// out_     | out | out_tvalid/tready  | tdata out_byte/char_count/check_failed,
//          |     |                    | tuser kind, tlast last_result
// cfg_     | in  | cfg_valid/ready    | cfg_index register, cfg_data value
//
// one byte request per cycle enters the front while the queue is not full; it settles up to three
// characters in that same cycle and queues at most one record of output work
// the back drains one result per cycle while out_tready allows, so a byte yields
// 0 to 4 results (kept bytes plus the summary); a four-entry queue between them absorbs this
// rst_n is synchronous, active low; it clears string state and the registers
// in_tready drops only while the queue is full; cfg is always ready
module utf8_cjk_char_count_check #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] out_byte, [23:8] char_count, [24] check_failed
  output logic        out_tuser,   // [0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ucc_pkg::*;

  // configuration registers
  mode_t              mode_r;
  logic [LIMIT_W-1:0] limit_r;

  // front to queue to back
  rec_t    f_rec;
  rec_t    q_head;
  logic    q_push;
  logic    q_pop;
  q_stat_t q_stat;
  logic    in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_COUNT;
      limit_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:  mode_r  <= mode_t'(cfg_data[1:0]);
        REG_LIMIT: limit_r <= cfg_data;
        default:   mode_r  <= mode_r;
      endcase
    end
  end

  // front: holds undecided bytes, classifies and counts characters
  ucc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .mode    (mode_r),
    .limit   (limit_r),
    .rec     (f_rec),
    .push    (q_push)
  );

  // short queue of pending output work
  ucc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (f_rec),
    .pop      (q_pop),
    .head_rec (q_head),
    .stat     (q_stat)
  );

  // back: turns each record into its kept bytes and, when it closes a string, a summary
  ucc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (q_head),
    .head_valid (q_stat.not_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`include "utf8_cjk_char_count_check_defines.svh"

  `UCC_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full, "push into full queue")
  `UCC_ASSERT_IMP(a_summary_last, out_tvalid && out_tuser == KIND_SUMMARY,
    out_tlast && out_tdata[7:0] == 8'd0, "summary request malformed")
  `UCC_ASSERT_IMP(a_byte_plain, out_tvalid && out_tuser == KIND_BYTE,
    !out_tlast && out_tdata[24:8] == 17'd0, "kept byte request malformed")

endmodule

// File: rtl/core/ucc_front.sv
module ucc_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_acc,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  input  ucc_pkg::mode_t             mode,
  input  logic [ucc_pkg::LIMIT_W-1:0] limit,
  output ucc_pkg::rec_t              rec,
  output logic                       push
);
  import ucc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic [2:0][7:0]        pend_r, pend_nxt;
  logic [1:0]             pcnt_r, pcnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   failed_r, failed_nxt;
  logic                   stopped_r, stopped_nxt;

  logic [2:0][7:0]        bq;
  logic [COUNT_WIDTH-1:0] cnt_v;
  logic                   fail_v;
  logic [1:0]             nkeep_v;

  always_comb begin
    logic [1:0] n;
    logic [1:0] pos;
    logic [1:0] len;
    logic [2:0] idx;
    logic       at_end;
    logic       stop;
    logic       done;
    logic       ok;
    logic       zero_b;
    logic [7:0] c;
    bq      = pend_r;
    n       = pcnt_r;
    pos     = '0;
    at_end  = in_last;
    stop    = stopped_r;
    done    = 1'b0;
    cnt_v   = cnt_r;
    fail_v  = failed_r;
    nkeep_v = '0;
    zero_b  = (in_byte == 8'd0);
    len     = '0;
    ok      = 1'b1;
    c       = '0;
    idx     = '0;
    if (!stopped_r) begin
      if (zero_b) begin
        at_end = 1'b1;
      end else begin
        bq[pcnt_r] = in_byte;
        n = pcnt_r + 2'd1;
      end
    end
    // at most three characters settle per byte
    for (int i = 0; i < 3; i++) begin
      if (n != 2'd0 && !stop && !done) begin
        c   = bq[pos];
        len = 2'd1;
        if (c[7:4] == 4'hE) begin
          if (n != 2'd3) begin
            if (!at_end) len = 2'd0;
          end else if (is_cjk(bq[0], bq[1], bq[2])) begin
            len = 2'd3;
          end
        end
        if (len == 2'd0) begin
          done = 1'b1;
        end else begin
          case (mode)
            MODE_ALNUM: ok = (len == 2'd3) || is_alpha(c) || is_digit(c);
            MODE_DIGIT: ok = (len == 2'd1) && is_digit(c);
            default:    ok = 1'b1;
          endcase
          if (!ok) begin
            fail_v = 1'b1;
            stop   = 1'b1;
            n      = '0;
          end else begin
            if (!(&cnt_v)) cnt_v = cnt_v + COUNT_WIDTH'(1);
            if (mode == MODE_TRUNC) nkeep_v = nkeep_v + len;
            pos = pos + len;
            n   = n - len;
            if (mode == MODE_TRUNC && limit != '0 &&
                CMP_W'(cnt_v) == CMP_W'(limit)) begin
              stop = 1'b1;
              n    = '0;
            end
          end
        end
      end
    end
    for (int j = 0; j < 3; j++) begin
      idx = 3'(j) + {1'b0, pos};
      pend_nxt[j] = (idx < 3'd3) ? bq[idx[1:0]] : 8'd0;
    end
    stopped_nxt = stop || (!stopped_r && zero_b);
    pcnt_nxt    = stopped_nxt ? 2'd0 : n;
    cnt_nxt     = cnt_v;
    failed_nxt  = fail_v;
    if (in_last) begin
      pend_nxt    = '0;
      pcnt_nxt    = '0;
      cnt_nxt     = '0;
      failed_nxt  = 1'b0;
      stopped_nxt = 1'b0;
    end
  end

  always_comb begin
    rec.bytes = bq;
    rec.nkeep = nkeep_v;
    rec.summ  = in_last;
    rec.cnt   = CHAR_W'(cnt_v);
    rec.fail  = fail_v;
    push      = in_acc && (nkeep_v != 2'd0 || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      pcnt_r    <= '0;
      cnt_r     <= '0;
      failed_r  <= 1'b0;
      stopped_r <= 1'b0;
    end else if (in_acc) begin
      pend_r    <= pend_nxt;
      pcnt_r    <= pcnt_nxt;
      cnt_r     <= cnt_nxt;
      failed_r  <= failed_nxt;
      stopped_r <= stopped_nxt;
    end
  end

`include "utf8_cjk_char_count_check_defines.svh"

  `UCC_ASSERT_IMP(a_pend_lt3, 1'b1, pcnt_r != 2'd3, "held byte count reached three")
  `UCC_ASSERT_IMP(a_stop_empty, stopped_r, pcnt_r == 2'd0, "bytes held after stop")
  `UCC_ASSERT_NXT(a_end_clear, in_acc && in_last,
    pcnt_r == 2'd0 && cnt_r == '0 && !failed_r && !stopped_r, "state not cleared at end")

endmodule

// File: rtl/core/ucc_queue.sv
module ucc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ucc_pkg::rec_t     push_rec,
  input  logic              pop,
  output ucc_pkg::rec_t     head_rec,
  output ucc_pkg::q_stat_t  stat
);
  import ucc_pkg::*;

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    stat.full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
    stat.not_empty = (cnt_r != '0);
    head_rec       = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/ucc_back.sv
module ucc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ucc_pkg::rec_t              head_rec,
  input  logic                       head_valid,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);
  import ucc_pkg::*;

  logic [1:0]  beat_r, beat_nxt;
  logic        vld_r, vld_nxt;
  logic [31:0] data_r, data_nxt;
  logic        user_r, user_nxt;
  logic        last_r, last_nxt;
  logic        ld;
  logic        fin;
  logic [2:0]  nbeats;

  always_comb begin
    ld       = head_valid && (!vld_r || out_tready);
    nbeats   = {1'b0, head_rec.nkeep} + {2'b00, head_rec.summ};
    fin      = ({1'b0, beat_r} + 3'd1) == nbeats;
    pop      = ld && fin;
    beat_nxt = beat_r;
    data_nxt = data_r;
    user_nxt = user_r;
    last_nxt = last_r;
    vld_nxt  = out_tready ? 1'b0 : vld_r;
    if (ld) begin
      vld_nxt  = 1'b1;
      beat_nxt = fin ? 2'd0 : beat_r + 2'd1;
      if (beat_r < head_rec.nkeep) begin
        data_nxt = {24'd0, head_rec.bytes[beat_r]};
        user_nxt = KIND_BYTE;
        last_nxt = 1'b0;
      end else begin
        data_nxt = {7'd0, head_rec.fail, head_rec.cnt, 8'd0};
        user_nxt = KIND_SUMMARY;
        last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule
